@@ rtl/core/date_difference_in_days_core_defines.svh @@
// Assertion macros shared by the date difference core modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef DATE_DIFFERENCE_IN_DAYS_CORE_DEFINES_SVH
`define DATE_DIFFERENCE_IN_DAYS_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DATEDIFF_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("datediff: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define DATEDIFF_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("datediff: next-cycle check failed");

`endif

@@ rtl/core/datediff_pkg.sv @@
// Types, constants and calendar tables for the date difference core.
// Has no dependencies; used by every module of the core.
package datediff_pkg;

   localparam int unsigned DAY_W   = 5;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned COUNT_W = 22;

   // Operand width of the shared divide-by-25 multiplier.
   localparam int unsigned DIVOP_W = 12;
   localparam int unsigned PROD_W  = 24;

   // floor(x * 2622 / 65536) equals floor(x / 25) for every x below 4681.
   localparam logic [DIVOP_W-1:0] RECIP25 = 12'd2622;
   localparam int unsigned RECIP_SHIFT = 16;

   localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
   localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [DAY_W-1:0]   start_day;
      logic [MONTH_W-1:0] start_month;
      logic [YEAR_W-1:0]  start_year;
      logic [DAY_W-1:0]   end_day;
      logic [MONTH_W-1:0] end_month;
      logic [YEAR_W-1:0]  end_year;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0] day_count;
      logic               date_invalid;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV100,
      ST_DIV400,
      ST_YEARS,
      ST_DAYNUM,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic load;       // capture the request beat
      logic sel_end;    // work on the end date rather than the start date
      logic div100_en;  // multiply (p/4) by the reciprocal of 25
      logic div400_en;  // keep p/100, multiply (p/16) by the reciprocal of 25
      logic years_en;   // days in the whole years before the date, leap flag
      logic daynum_en;  // serial day number and validity of the date
      logic result_en;  // write the response register
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
      logic [8:0] r;
      begin
         case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
         endcase
         return r;
      end
   endfunction

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
      logic [DAY_W-1:0] r;
      begin
         case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
            4'd2:    r = leap ? 5'd29 : 5'd28;
            default: r = 5'd0;
         endcase
         return r;
      end
   endfunction

endpackage

@@ rtl/core/datediff_ctrl.sv @@
// Sequencer of the date difference core: steps the datapath through both dates.
// Depends on datediff_pkg and the core's assertion macro header.
`include "date_difference_in_days_core_defines.svh"

module datediff_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  datediff_pkg::status_type status,
   output datediff_pkg::cmd_type    cmd
);

   datediff_pkg::state_type state_ff, state_in;
   logic sel_end_ff, sel_end_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= datediff_pkg::ST_IDLE;
         sel_end_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sel_end_ff <= sel_end_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      sel_end_in = sel_end_ff;
      unique case (state_ff)
         datediff_pkg::ST_IDLE: begin
            sel_end_in = 1'b0;
            if (req_valid) begin
               state_in = datediff_pkg::ST_DIV100;
            end
         end
         datediff_pkg::ST_DIV100: state_in = datediff_pkg::ST_DIV400;
         datediff_pkg::ST_DIV400: state_in = datediff_pkg::ST_YEARS;
         datediff_pkg::ST_YEARS:  state_in = datediff_pkg::ST_DAYNUM;
         datediff_pkg::ST_DAYNUM: begin
            if (sel_end_ff) begin
               state_in = datediff_pkg::ST_RESULT;
            end else begin
               sel_end_in = 1'b1;
               state_in   = datediff_pkg::ST_DIV100;
            end
         end
         datediff_pkg::ST_RESULT: begin
            // Hold here until the response register has been emptied.
            if (status.out_free) begin
               sel_end_in = 1'b0;
               state_in   = datediff_pkg::ST_IDLE;
            end
         end
         default: state_in = datediff_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.sel_end = sel_end_ff;
      req_ready   = 1'b0;
      unique case (state_ff)
         datediff_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         datediff_pkg::ST_DIV100: cmd.div100_en = 1'b1;
         datediff_pkg::ST_DIV400: cmd.div400_en = 1'b1;
         datediff_pkg::ST_YEARS:  cmd.years_en  = 1'b1;
         datediff_pkg::ST_DAYNUM: cmd.daynum_en = 1'b1;
         datediff_pkg::ST_RESULT: cmd.result_en = status.out_free;
         default: cmd = '0;
      endcase
   end

   `DATEDIFF_ASSERT_IMP(a_result_needs_room, clock, reset,
      cmd.result_en, status.out_free)
   `DATEDIFF_ASSERT_IMP(a_result_after_end_date, clock, reset,
      state_ff == datediff_pkg::ST_RESULT, sel_end_ff)
   `DATEDIFF_ASSERT_NXT(a_start_then_end, clock, reset,
      (state_ff == datediff_pkg::ST_DAYNUM) && !sel_end_ff,
      (state_ff == datediff_pkg::ST_DIV100) && sel_end_ff)

endmodule

@@ rtl/core/datediff_dp.sv @@
// Datapath of the date difference core: request and response registers,
// the shared divide-by-25 multiplier and the day number arithmetic.
// Depends on datediff_pkg and the core's assertion macro header.
`include "date_difference_in_days_core_defines.svh"

module datediff_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_wdata,
   input  datediff_pkg::req_payload_type req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output datediff_pkg::rsp_payload_type rsp_data,
   input  datediff_pkg::cmd_type         cmd,
   output datediff_pkg::status_type      status
);

   localparam int unsigned CW = datediff_pkg::COUNT_W;
   localparam int unsigned YW = datediff_pkg::YEAR_W;

   logic                          include_end_ff;
   datediff_pkg::req_payload_type req_ff;
   logic [datediff_pkg::PROD_W-1:0] product_ff, product_in;
   logic [7:0]                    q100_ff;
   logic [CW-1:0]                 years_ff, years_in;
   logic                          leap_ff, leap_in;
   logic [CW-1:0]                 start_num_ff, end_num_ff, daynum_in;
   logic                          start_ok_ff, end_ok_ff, date_ok_in;
   logic                          rsp_valid_ff;
   datediff_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [datediff_pkg::DAY_W-1:0]   day;
   logic [datediff_pkg::MONTH_W-1:0] month;
   logic [YW-1:0]                    year;
   logic [YW-1:0]                    prev_year;
   logic [datediff_pkg::DIVOP_W-1:0] div_opnd;
   logic [5:0]                       q400;
   logic [YW-1:0]                    rem100, rem400;
   logic [CW-1:0]                    span;

   always_comb begin
      day   = cmd.sel_end ? req_ff.end_day   : req_ff.start_day;
      month = cmd.sel_end ? req_ff.end_month : req_ff.start_month;
      year  = cmd.sel_end ? req_ff.end_year  : req_ff.start_year;
      prev_year = year - YW'(1);
   end

   // One multiplier serves both quotients: p/100 = (p/4)/25, p/400 = (p/16)/25.
   always_comb begin
      if (cmd.div400_en) begin
         div_opnd = {2'b00, prev_year[YW-1:4]};
      end else begin
         div_opnd = prev_year[YW-1:2];
      end
      product_in = datediff_pkg::PROD_W'(div_opnd) *
                   datediff_pkg::PROD_W'(datediff_pkg::RECIP25);
   end

   always_comb begin
      q400     = product_ff[datediff_pkg::RECIP_SHIFT +: 6];
      years_in = CW'(prev_year) * CW'(365) + CW'(prev_year[YW-1:2])
                 - CW'(q100_ff) + CW'(q400);
      rem100   = prev_year - YW'(q100_ff) * YW'(100);
      rem400   = prev_year - YW'(q400) * YW'(400);
      // The year itself is a leap year when p mod 4 is 3, p mod 100 is not 99,
      // or when p mod 400 is 399.
      leap_in  = ((prev_year[1:0] == 2'b11) && (rem100 != YW'(99))) ||
                 (rem400 == YW'(399));
   end

   always_comb begin
      date_ok_in = (year >= datediff_pkg::YEAR_MIN) && (year <= datediff_pkg::YEAR_MAX) &&
                   (month >= datediff_pkg::MONTH_JAN) && (month <= datediff_pkg::MONTH_DEC) &&
                   (day != '0) && (day <= datediff_pkg::month_length(month, leap_ff));
      daynum_in  = years_ff + CW'(datediff_pkg::days_before_month(month)) +
                   CW'(leap_ff && (month > datediff_pkg::MONTH_FEB)) + CW'(day);
   end

   always_comb begin
      span   = (start_num_ff < end_num_ff) ? (end_num_ff - start_num_ff) : '0;
      rsp_in = '0;
      if (start_ok_ff && end_ok_ff) begin
         rsp_in.day_count = span + CW'(include_end_ff);
      end else begin
         rsp_in.date_invalid = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         include_end_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            include_end_ff <= csr_wdata;
         end
         if (cmd.result_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.div100_en || cmd.div400_en) begin
         product_ff <= product_in;
      end
      if (cmd.div400_en) begin
         q100_ff <= product_ff[datediff_pkg::RECIP_SHIFT +: 8];
      end
      if (cmd.years_en) begin
         years_ff <= years_in;
         leap_ff  <= leap_in;
      end
      if (cmd.daynum_en) begin
         if (cmd.sel_end) begin
            end_num_ff <= daynum_in;
            end_ok_ff  <= date_ok_in;
         end else begin
            start_num_ff <= daynum_in;
            start_ok_ff  <= date_ok_in;
         end
      end
      if (cmd.result_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   `DATEDIFF_ASSERT_IMP(a_invalid_means_zero, clock, reset,
      rsp_valid_ff && rsp_ff.date_invalid, rsp_ff.day_count == '0)
   `DATEDIFF_ASSERT_NXT(a_result_sets_valid, clock, reset,
      cmd.result_en, rsp_valid_ff)

endmodule

@@ rtl/core/date_difference_in_days_core.sv @@
// Top level of the date difference core: days between two Gregorian dates.
// Depends on datediff_pkg, datediff_ctrl and datediff_dp.
//
// Usage: a request beat on req_valid/req_ready carries a start and an end
// date (day, month, year). One response beat on rsp_valid/rsp_ready returns
// day_count, the number of days from start to end (0 when the start is not
// earlier), plus one when the include_end_day bit is set, and date_invalid
// when either date has a bad day, month or year, with day_count then 0.
// The include_end_day bit is written through csr_we/csr_wdata by the user
// only while idle; the core does not enforce this. Each date takes four
// sequencer steps through one shared 12x12 multiplier that forms the
// quotients by 100 and by 400; rsp_valid is set with the output register
// in the result step, and a new request is taken only in idle. While the
// receiver stalls, the core finishes the next item and then waits with it
// until the output register is emptied. Synchronous reset clears the
// sequencer, the response valid and include_end_day.
module date_difference_in_days_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  datediff_pkg::req_payload_type req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output datediff_pkg::rsp_payload_type rsp_data
);

   datediff_pkg::cmd_type    cmd;
   datediff_pkg::status_type status;

   datediff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   datediff_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
